// ----- hw/rtl/pcrc_pkg.sv -----
// shared types, constants and crc table for the png chunk crc rewriter
`timescale 1ns / 1ps

package pcrc_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [31:0] TYPE_IDAT     = 32'h4944_4154;
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOR_OUT   = 32'hFFFF_FFFF;

    // first and last byte indices of the fixed-size phases
    localparam logic [2:0] SIG_LAST_IDX   = 3'd7;
    localparam logic [2:0] FIELD_LAST_IDX = 3'd3;
    localparam logic [2:0] FIRST_IDX      = 3'd0;

    typedef enum logic [4:0] {
        PH_SIG  = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_TYPE = 5'b00100,
        PH_DATA = 5'b01000,
        PH_CRC  = 5'b10000
    } phase_t;

    // one classified beat handed from the parser to the crc engine
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       crc_init;
        logic       crc_feed;
        logic       crc_emit;
        logic [1:0] emit_idx;
    } cmd_t;

    typedef logic [31:0] crc_table_t [256];

    function automatic crc_table_t gen_crc_table();
        crc_table_t tbl;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = gen_crc_table();

endpackage

// ----- hw/rtl/pcrc_parser.sv -----
// front end: walks the png chunk structure and classifies each byte
`timescale 1ns / 1ps

module pcrc_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       byte_in,
    input  logic             start_of_file,
    input  logic             last_of_file,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      target_chunk_type,
    output logic             push,
    output pcrc_pkg::cmd_t   push_cmd,
    input  logic             queue_full
);
    import pcrc_pkg::*;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [2:0]  cnt_reg, cnt_next, cnt_eff, cnt_inc;
    logic [31:0] len_reg, len_next;
    logic [31:0] type_reg, type_next;
    logic        match_reg, match_next;
    logic [31:0] target_reg;
    logic        accept;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign push      = accept;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        phase_eff  = start_of_file ? PH_SIG : phase_reg;
        cnt_eff    = start_of_file ? FIRST_IDX : cnt_reg;
        cnt_inc    = cnt_eff + 3'd1;
        phase_next = phase_eff;
        cnt_next   = cnt_inc;
        len_next   = len_reg;
        type_next  = type_reg;
        match_next = start_of_file ? 1'b0 : match_reg;

        push_cmd          = '0;
        push_cmd.data     = byte_in;
        push_cmd.last     = last_of_file;
        push_cmd.emit_idx = cnt_eff[1:0];

        case (phase_eff)
            PH_SIG:
            begin
                if (cnt_eff == SIG_LAST_IDX)
                begin
                    phase_next = PH_LEN;
                    cnt_next   = FIRST_IDX;
                    len_next   = '0;
                end
            end
            PH_LEN:
            begin
                len_next = {len_reg[23:0], byte_in};
                if (cnt_eff == FIELD_LAST_IDX)
                begin
                    phase_next = PH_TYPE;
                    cnt_next   = FIRST_IDX;
                    type_next  = '0;
                end
            end
            PH_TYPE:
            begin
                type_next         = {type_reg[23:0], byte_in};
                push_cmd.crc_feed = 1'b1;
                push_cmd.crc_init = (cnt_eff == FIRST_IDX);
                if (cnt_eff == FIELD_LAST_IDX)
                begin
                    match_next = ({type_reg[23:0], byte_in} == target_reg);
                    cnt_next   = FIRST_IDX;
                    phase_next = (len_reg != '0) ? PH_DATA : PH_CRC;
                end
            end
            PH_DATA:
            begin
                // length counts down to the last data byte
                push_cmd.crc_feed = 1'b1;
                len_next          = len_reg - 32'd1;
                cnt_next          = FIRST_IDX;
                if (len_reg == 32'd1)
                begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                push_cmd.crc_emit = match_reg;
                if (cnt_eff == FIELD_LAST_IDX)
                begin
                    phase_next = PH_LEN;
                    cnt_next   = FIRST_IDX;
                    len_next   = '0;
                end
            end
            default:
            begin
                phase_next = PH_SIG;
                cnt_next   = FIRST_IDX;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            cnt_reg    <= FIRST_IDX;
            len_reg    <= '0;
            type_reg   <= '0;
            match_reg  <= 1'b0;
            target_reg <= TYPE_IDAT;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                len_reg   <= len_next;
                type_reg  <= type_next;
                match_reg <= match_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                target_reg <= target_chunk_type;
            end
        end
    end

endmodule

// ----- hw/rtl/pcrc_queue.sv -----
// small fifo of classified beats between parser and crc engine
`timescale 1ns / 1ps

module pcrc_queue #(
    parameter int unsigned DEPTH = pcrc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pcrc_pkg::cmd_t   push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output pcrc_pkg::cmd_t   pop_cmd
);
    import pcrc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/pcrc_engine.sv -----
// back end: table-driven crc-32 update and registered output beat
`timescale 1ns / 1ps

module pcrc_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  pcrc_pkg::cmd_t   cmd,
    output logic             cmd_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       byte_out,
    output logic             crc_rewritten,
    output logic             last_out
);
    import pcrc_pkg::*;

    logic [31:0] crc_reg, crc_next, crc_cur, crc_fin;
    logic [1:0]  byte_sel;
    logic [7:0]  emit_byte;
    logic        out_valid_reg;
    logic [7:0]  byte_out_reg;
    logic        rewritten_reg;
    logic        last_reg;

    assign cmd_pop = cmd_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        crc_cur  = cmd.crc_init ? CRC_INIT : crc_reg;
        crc_next = crc_reg;
        if (cmd.crc_feed)
        begin
            crc_next = (crc_cur >> 8) ^ CRC_TABLE[crc_cur[7:0] ^ cmd.data];
        end
        // crc bytes leave most significant first
        crc_fin   = crc_reg ^ CRC_XOR_OUT;
        byte_sel  = ~cmd.emit_idx;
        emit_byte = crc_fin[{byte_sel, 3'b000} +: 8];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            byte_out_reg  <= cmd.crc_emit ? emit_byte : cmd.data;
            rewritten_reg <= cmd.crc_emit;
            last_reg      <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_INIT;
        end
        else
        begin
            if (cmd_pop)
            begin
                out_valid_reg <= 1'b1;
                crc_reg       <= crc_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_out      = byte_out_reg;
    assign crc_rewritten = rewritten_reg;
    assign last_out      = last_reg;

endmodule

// ----- hw/rtl/png_idat_crc_fixer.sv -----
// top level of the png chunk crc rewriter
`timescale 1ns / 1ps

// Streams a PNG file one byte per beat and returns every byte in order. The
// 8-byte signature passes untouched; each chunk is parsed as length, type,
// data and crc. For chunks whose type equals target_chunk_type (IDAT after
// reset) the four crc bytes are replaced, most significant first, by the
// CRC-32 of the type and data bytes, and crc_rewritten flags those beats.
// start_of_file on a beat restarts parsing with that beat as signature byte
// zero; last_of_file is only copied to last_out. Throughput is one byte per
// cycle while the output does not stall: the parser classifies a byte in its
// accept cycle, and the crc engine does one table lookup per byte. Each beat
// is written into a queue slot at the accept edge, and the output register
// loads the oldest queued beat whenever it is empty or being read. The queue
// between parser and engine (QUEUE_DEPTH beats) absorbs output stalls so
// input keeps flowing until it fills. The config register may only be
// written while no beat is in flight; cfg_ready is always high.

module png_idat_crc_fixer #(
    parameter int unsigned QUEUE_DEPTH = pcrc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // input byte channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        start_of_file,
    input  logic        last_of_file,
    // output byte channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_out,
    output logic        crc_rewritten,
    output logic        last_out,
    // target chunk type write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] target_chunk_type
);
    import pcrc_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    logic pop_valid;
    cmd_t pop_cmd;

    // front end: chunk parser and type compare
    pcrc_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .byte_in           (byte_in),
        .start_of_file     (start_of_file),
        .last_of_file      (last_of_file),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .target_chunk_type (target_chunk_type),
        .push              (push),
        .push_cmd          (push_cmd),
        .queue_full        (queue_full)
    );

    // decoupling queue of classified beats
    pcrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    // back end: crc update, crc byte substitution, output register
    pcrc_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (pop_valid),
        .cmd           (pop_cmd),
        .cmd_pop       (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_out      (byte_out),
        .crc_rewritten (crc_rewritten),
        .last_out      (last_out)
    );

endmodule
